### src/block_biquad_iir_eight_lane_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the eight-lane block biquad
// Shared property wrappers on the block clock, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BIQUAD_IIR_EIGHT_LANE_ASSERT_SVH
`define BLOCK_BIQUAD_IIR_EIGHT_LANE_ASSERT_SVH

// Property checked on every rising clock edge, ignored while reset is active.
`define BBIQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BBIQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/bbiq_pkg.sv
// ----------------------------------------------------------------------------
// Block biquad package
// Default sizes, fixed field widths and item mode codes for the block biquad.
// ----------------------------------------------------------------------------
`default_nettype none

package bbiq_pkg;

    // Default sizes of the block.
    localparam int LANES_DEF        = 8;
    localparam int COLUMNS_DEF      = 12;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 24;

    // Fixed field width of the coefficient position.
    localparam int COEF_INDEX_WIDTH = 7;

    // Fraction bits of the Q4.20 coefficients, removed after the sum.
    localparam int FRAC_SHIFT = 20;

    // Columns taken by the history: y[-2], y[-1], x[-2], x[-1].
    localparam int HIST_COLUMNS = 4;

    // What an input item carries.
    typedef enum logic {
        MODE_COEF   = 1'b0,
        MODE_FILTER = 1'b1
    } t_mode;

endpackage

`default_nettype wire

### src/block_biquad_iir_eight_lane.sv
// ----------------------------------------------------------------------------
// Eight-lane block biquad IIR section
// Coefficient matrix, history and one registered pass per sample block.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless its input register holds
// a stalled sample block. An accepted item is captured in an input register,
// and from there all lanes of a sample block form their twelve products, sum,
// round and saturate in one pass into the result register as it moves on.
// The last two outputs fed back as history are written together with that
// result, so the next block can follow at once. A coefficient write takes
// effect for any sample block accepted after it, also in the very next cycle,
// and produces no result. Writes to positions at or beyond LANES*COLUMNS are
// dropped. The coefficient matrix and the history are cleared by reset; no
// clearing pass is needed. The input side keeps taking items while a result
// waits for the downstream side, until the input register itself is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module block_biquad_iir_eight_lane #(
    parameter int LANES        = bbiq_pkg::LANES_DEF,
    parameter int COLUMNS      = bbiq_pkg::COLUMNS_DEF,
    parameter int SAMPLE_WIDTH = bbiq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bbiq_pkg::COEF_WIDTH_DEF,
    localparam int S_RAW_W     = bbiq_pkg::COEF_INDEX_WIDTH + COEF_WIDTH
                                 + LANES * SAMPLE_WIDTH,
    localparam int S_TDATA_W   = ((S_RAW_W + 7) / 8) * 8,
    localparam int M_RAW_W     = LANES * SAMPLE_WIDTH,
    localparam int M_TDATA_W   = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input items
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // coef_index, coef_value, sample_0 .. sample_(LANES-1), zero fill
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // mode
    input  logic [0:0]           i_s_tuser,
    // Result items
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // out_0 .. out_(LANES-1), zero fill
    output logic [M_TDATA_W-1:0] o_m_tdata
);
    import bbiq_pkg::*;

    localparam int NCOEF   = LANES * COLUMNS;
    localparam int CADDR_W = $clog2(NCOEF);
    // One spare bit so that the matrix size itself always fits the compare.
    localparam int IDX_W   = ((CADDR_W > COEF_INDEX_WIDTH) ? CADDR_W : COEF_INDEX_WIDTH) + 1;
    localparam int VAL_LSB = COEF_INDEX_WIDTH;
    localparam int SMP_LSB = VAL_LSB + COEF_WIDTH;
    localparam logic [IDX_W-1:0] NCOEF_IDX = IDX_W'(NCOEF);

    // Input register
    logic                                 r_in_valid;
    t_mode                                r_in_mode;
    logic [COEF_INDEX_WIDTH-1:0]          r_in_idx;
    logic [COEF_WIDTH-1:0]                r_in_coef;
    logic [LANES-1:0][SAMPLE_WIDTH-1:0]   r_in_samp;

    // State
    logic [COEF_WIDTH-1:0]                r_coef [NCOEF];
    logic [SAMPLE_WIDTH-1:0]              r_hist_y2;
    logic [SAMPLE_WIDTH-1:0]              r_hist_y1;
    logic [SAMPLE_WIDTH-1:0]              r_hist_x2;
    logic [SAMPLE_WIDTH-1:0]              r_hist_x1;

    // Result register
    logic                                 r_out_valid;
    logic [M_RAW_W-1:0]                   r_out_data;

    logic                                 w_in_move;
    logic                                 w_in_load;
    logic                                 w_out_load;
    logic                                 w_coef_wr;
    logic [IDX_W-1:0]                     w_idx_ext;
    logic [COLUMNS*SAMPLE_WIDTH-1:0]      w_vec;
    logic [COLUMNS*COEF_WIDTH-1:0]        w_lane_coef [LANES];
    logic [LANES-1:0][SAMPLE_WIDTH-1:0]   w_y;

    // Handshake: a coefficient item always leaves the input register, a
    // sample block leaves when the result register is free or being taken.
    assign w_in_move  = r_in_valid
                        && ((r_in_mode == MODE_COEF) || !r_out_valid || i_m_tready);
    assign w_in_load  = !r_in_valid || w_in_move;
    assign w_out_load = w_in_move && (r_in_mode == MODE_FILTER);
    assign o_s_tready = i_rst_n && w_in_load;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_mode <= t_mode'(i_s_tuser[0]);
            r_in_idx  <= i_s_tdata[COEF_INDEX_WIDTH-1:0];
            r_in_coef <= i_s_tdata[VAL_LSB +: COEF_WIDTH];
            r_in_samp <= i_s_tdata[SMP_LSB +: LANES*SAMPLE_WIDTH];
        end
    end

    // Coefficient write, dropped beyond the end of the matrix.
    assign w_idx_ext = IDX_W'(r_in_idx);
    assign w_coef_wr = w_in_move && (r_in_mode == MODE_COEF) && (w_idx_ext < NCOEF_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NCOEF; e++) begin
                r_coef[e] <= '0;
            end
        end else if (w_coef_wr) begin
            r_coef[w_idx_ext[CADDR_W-1:0]] <= r_in_coef;
        end
    end

    // Block vector: history first, then the samples, zero past the samples.
    genvar c, k;
    generate
        for (c = 0; c < COLUMNS; c++) begin : g_vec
            if (c == 0) begin : g_y2
                assign w_vec[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] = r_hist_y2;
            end else if (c == 1) begin : g_y1
                assign w_vec[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] = r_hist_y1;
            end else if (c == 2) begin : g_x2
                assign w_vec[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] = r_hist_x2;
            end else if (c == 3) begin : g_x1
                assign w_vec[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] = r_hist_x1;
            end else if (c - HIST_COLUMNS < LANES) begin : g_smp
                assign w_vec[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] = r_in_samp[c - HIST_COLUMNS];
            end else begin : g_zero
                assign w_vec[c*SAMPLE_WIDTH +: SAMPLE_WIDTH] = '0;
            end
        end

        // One dot-product lane per output, fed by its column of the matrix.
        for (k = 0; k < LANES; k++) begin : g_lane
            for (c = 0; c < COLUMNS; c++) begin : g_col
                assign w_lane_coef[k][c*COEF_WIDTH +: COEF_WIDTH] = r_coef[LANES*c + k];
            end

            bbiq_lane #(
                .COLUMNS      (COLUMNS),
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .COEF_WIDTH   (COEF_WIDTH)
            ) u_lane (
                .i_coef (w_lane_coef[k]),
                .i_vec  (w_vec),
                .o_y    (w_y[k])
            );
        end
    endgenerate

    // History follows each sample block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_y2 <= '0;
            r_hist_y1 <= '0;
            r_hist_x2 <= '0;
            r_hist_x1 <= '0;
        end else if (w_out_load) begin
            r_hist_y2 <= w_y[LANES-2];
            r_hist_y1 <= w_y[LANES-1];
            r_hist_x2 <= r_in_samp[LANES-2];
            r_hist_x1 <= r_in_samp[LANES-1];
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_y;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_data);

endmodule

`default_nettype wire

### src/bbiq_lane.sv
// ----------------------------------------------------------------------------
// Block biquad output lane
// Dot product of one coefficient column set with the block vector, rounded
// half-up, shifted down by the fraction bits and saturated to sample width.
// ----------------------------------------------------------------------------
`default_nettype none

module bbiq_lane #(
    parameter int COLUMNS      = bbiq_pkg::COLUMNS_DEF,
    parameter int SAMPLE_WIDTH = bbiq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = bbiq_pkg::COEF_WIDTH_DEF
) (
    input  logic [COLUMNS*COEF_WIDTH-1:0]   i_coef,  // column 0 in the lowest bits
    input  logic [COLUMNS*SAMPLE_WIDTH-1:0] i_vec,   // column 0 in the lowest bits
    output logic [SAMPLE_WIDTH-1:0]         o_y
);
    import bbiq_pkg::*;

    localparam int PROD_W   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_FULL = PROD_W + $clog2(COLUMNS);
    // The sum wraps at 64 bits, which only matters at extreme sizes.
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int SH_W     = ACC_W - FRAC_SHIFT;
    localparam int EXT_W    = (SH_W > SAMPLE_WIDTH) ? SH_W : SAMPLE_WIDTH;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'd1 << (FRAC_SHIFT - 1));
    localparam logic signed [EXT_W-1:0] SAT_HI =
        {{(EXT_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO =
        {{(EXT_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [COEF_WIDTH-1:0]   cf;
    logic signed [PROD_W-1:0]       prod;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        w_rnd;
    logic signed [SH_W-1:0]         w_sh;
    logic signed [EXT_W-1:0]        w_ext;

    // Exact products summed over all columns.
    always_comb begin
        acc  = '0;
        smp  = '0;
        cf   = '0;
        prod = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            smp  = i_vec[c*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            cf   = i_coef[c*COEF_WIDTH +: COEF_WIDTH];
            prod = smp * cf;
            acc  = acc + ACC_W'(prod);
        end
    end

    // Round half-up, drop the fraction and widen for the range check.
    assign w_rnd = acc + RND;
    assign w_sh  = w_rnd[ACC_W-1:FRAC_SHIFT];
    assign w_ext = EXT_W'(w_sh);

    // Saturate to the sample range.
    always_comb begin
        if (w_ext > SAT_HI) begin
            o_y = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (w_ext < SAT_LO) begin
            o_y = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_y = w_ext[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

### src/bbiq_check.sv
// ----------------------------------------------------------------------------
// Block biquad port checker
// Watches the stream ports of the block biquad over time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "block_biquad_iir_eight_lane_assert.svh"

module bbiq_check #(
    parameter int M_TDATA_W = 128
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_tvalid,
    input wire logic                 o_s_tready,
    input wire logic [0:0]           i_s_tuser,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata
);
    import bbiq_pkg::*;

    logic w_blk_acc;

    // A sample block is accepted.
    assign w_blk_acc = i_s_tvalid && o_s_tready && (i_s_tuser[0] == MODE_FILTER);

    // Reset leaves no result pending.
    `BBIQ_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid,
        "result valid right after reset")

    // A stalled result keeps its data.
    `BBIQ_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata),
        "stalled result changed or vanished")

    // Every accepted sample block is followed by a valid result.
    `BBIQ_ASSERT(a_blk_result, w_blk_acc |=> ##1 o_m_tvalid,
        "sample block gave no result after two cycles")

    // A fresh result comes only from an earlier accepted sample block.
    `BBIQ_ASSERT(a_no_spurious, $rose(o_m_tvalid) |-> $past(w_blk_acc, 2),
        "result appeared without a sample block")

endmodule

bind block_biquad_iir_eight_lane bbiq_check #(
    .M_TDATA_W (M_TDATA_W)
) u_bbiq_check (.*);

`default_nettype wire
